[hw/rtl/wrpa_pkg.sv]
// Package with the shared types, widths and codes of the windowed rate averager.
`timescale 1ns / 1ps

package wrpa_pkg;

    // Fixed field widths.
    localparam int RATE_W     = 32;
    localparam int CAP_W      = 32;
    localparam int WLEN_W     = 5;
    localparam int AVG_W      = 32;
    localparam int PM_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = RATE_W;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 2 * AVG_W + 3 * PM_W;

    // Per-mille scale and the bits needed to hold it.
    localparam int PERMILLE_SCALE = 1000;
    localparam int SCALE_W        = 10;

    // Parameter defaults.
    localparam int DEF_MAX_WINDOW = 16;
    localparam int DEF_RATE_BITS  = 32;

    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(3);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IN_CAPACITY   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY  = CFG_IDX_W'(2);

    // Sample direction.
    localparam logic DIR_IN  = 1'b0;
    localparam logic DIR_OUT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DROP_CHK,
        ST_DROP_SUB,
        ST_STORE,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_PM_MUL,
        ST_PM_START,
        ST_PM_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PM_IN,
        PM_OUT,
        PM_TOTAL
    } pm_sel_t;

    // Request to the shared divider.
    typedef struct packed {
        logic start;
        logic avg_mode;
    } div_req_t;

endpackage

[hw/rtl/windowed_rate_average_permille_unit.sv]
// Top level of the windowed rate averager with per-mille load outputs.
// Each request drops the oldest samples until its window has room, stores the new sample,
// then runs the average and the three loads through the single bit-serial divider; a load
// whose capacity is zero or whose value saturates skips its division.
// A new request is taken only once the previous result has gone to the output register, so
// a result held back by the receiver delays the next request.
// Reset clears windows, averages and configuration registers (window length 3); no clearing pass.
`timescale 1ns / 1ps

module windowed_rate_average_permille_unit #(
    parameter int MAX_WINDOW = wrpa_pkg::DEF_MAX_WINDOW,
    parameter int RATE_BITS  = wrpa_pkg::DEF_RATE_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Request channel.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wrpa_pkg::S_TDATA_W-1:0]  s_tdata,   // rate_sample
    input  logic [wrpa_pkg::S_TUSER_W-1:0]  s_tuser,   // op
    // Result channel.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wrpa_pkg::M_TDATA_W-1:0]  m_tdata,   // in_average, out_average,
                                                       // in_permille, out_permille,
                                                       // total_permille
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [wrpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wrpa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wrpa_pkg::*;

    // Only the low RATE_BITS of a sample matter, and never more than the field.
    localparam int SAMPLE_W = (RATE_BITS < RATE_W) ? RATE_BITS : RATE_W;
    localparam int IDX_W    = $clog2(MAX_WINDOW);
    localparam int FILL_W   = $clog2(MAX_WINDOW + 1);
    localparam int TOTAL_W  = SAMPLE_W + FILL_W;
    localparam int OPND_W   = SAMPLE_W + 1;
    localparam int PMNUM_W  = OPND_W + SCALE_W;
    localparam int DIV_W    = (TOTAL_W > PMNUM_W) ? TOTAL_W : PMNUM_W;
    localparam int DEN_W    = CAP_W + 1;
    localparam int QW       = (SAMPLE_W > PM_W) ? SAMPLE_W : PM_W;
    localparam int ADDR_W   = IDX_W + 1;
    localparam int MEM_D    = 2 ** ADDR_W;

    // Configuration registers.
    logic [WLEN_W-1:0] wlen_reg;
    logic [CAP_W-1:0]  in_cap_reg;
    logic [CAP_W-1:0]  out_cap_reg;

    // Sequencer and per-request registers.
    state_t              state_reg, state_next;
    logic                dir_reg, dir_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [FILL_W-1:0]   len_reg, len_next;
    pm_sel_t             pm_sel_reg, pm_sel_next;
    logic [PMNUM_W-1:0]  mul_reg, mul_next;
    logic [PM_W-1:0]     in_pm_reg, in_pm_next;
    logic [PM_W-1:0]     out_pm_reg, out_pm_next;
    logic [PM_W-1:0]     tot_pm_reg, tot_pm_next;

    // Window bookkeeping, one entry per direction.
    logic [FILL_W-1:0]   fill_reg [2];
    logic [FILL_W-1:0]   fill_next [2];
    logic [IDX_W-1:0]    oldest_reg [2];
    logic [IDX_W-1:0]    oldest_next [2];
    logic [TOTAL_W-1:0]  total_reg [2];
    logic [TOTAL_W-1:0]  total_next [2];
    // Each direction's average only changes when it gets a sample of its own,
    // so the other one is kept here instead of being divided again.
    logic [SAMPLE_W-1:0] avg_reg [2];
    logic [SAMPLE_W-1:0] avg_next [2];

    // Output register.
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Sample memory: both windows, the direction selecting the upper half.
    logic [SAMPLE_W-1:0] win_mem [MEM_D];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [ADDR_W-1:0]   mem_waddr;
    logic                mem_we;

    // Shared divider.
    div_req_t         div_req;
    logic [DIV_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [QW-1:0]    div_quot;

    logic [FILL_W-1:0] len_eff;
    logic [IDX_W:0]    oldest_inc;
    logic [FILL_W:0]   slot_sum;
    logic [IDX_W-1:0]  slot;
    logic [OPND_W-1:0] pm_operand;
    logic [DEN_W-1:0]  pm_den;

    // A window length of zero acts as one, and anything past the storage as
    // the full storage.
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            len_eff = FILL_W'(1);
        end
        else if (int'(wlen_reg) > MAX_WINDOW)
        begin
            len_eff = FILL_W'(MAX_WINDOW);
        end
        else
        begin
            len_eff = FILL_W'(wlen_reg);
        end
    end

    // Circular-buffer pointer arithmetic for the current direction. The fill
    // is below the window length when a sample is stored, so the slot sum
    // stays under twice the depth.
    always_comb
    begin
        oldest_inc = {1'b0, oldest_reg[dir_reg]} + (IDX_W + 1)'(1);
        if (oldest_inc == (IDX_W + 1)'(MAX_WINDOW))
        begin
            oldest_inc = '0;
        end
        slot_sum = (FILL_W + 1)'(oldest_reg[dir_reg]) + (FILL_W + 1)'(fill_reg[dir_reg]);
        if (slot_sum >= (FILL_W + 1)'(MAX_WINDOW))
        begin
            slot_sum = slot_sum - (FILL_W + 1)'(MAX_WINDOW);
        end
        slot = slot_sum[IDX_W-1:0];
    end

    // Operands of the three loads; the total load divides by the 33-bit sum of
    // both capacities.
    always_comb
    begin
        case (pm_sel_reg)
            PM_IN:
            begin
                pm_operand = OPND_W'(avg_reg[DIR_IN]);
                pm_den     = DEN_W'(in_cap_reg);
            end
            PM_OUT:
            begin
                pm_operand = OPND_W'(avg_reg[DIR_OUT]);
                pm_den     = DEN_W'(out_cap_reg);
            end
            PM_TOTAL:
            begin
                pm_operand = OPND_W'(avg_reg[DIR_IN]) + OPND_W'(avg_reg[DIR_OUT]);
                pm_den     = DEN_W'(in_cap_reg) + DEN_W'(out_cap_reg);
            end
            default:
            begin
                pm_operand = '0;
                pm_den     = '0;
            end
        endcase
    end

    // Sequencer: drop the oldest samples one at a time until there is room,
    // store the new sample, divide for the average, then run the three loads
    // through the same divider.
    always_comb
    begin
        state_next    = state_reg;
        dir_next      = dir_reg;
        sample_next   = sample_reg;
        len_next      = len_reg;
        pm_sel_next   = pm_sel_reg;
        mul_next      = mul_reg;
        in_pm_next    = in_pm_reg;
        out_pm_next   = out_pm_reg;
        tot_pm_next   = tot_pm_reg;
        fill_next     = fill_reg;
        oldest_next   = oldest_reg;
        total_next    = total_reg;
        avg_next      = avg_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = {dir_reg, oldest_reg[dir_reg]};
        mem_waddr = {dir_reg, slot};
        div_req   = '0;
        div_num   = DIV_W'(mul_reg);
        div_den   = pm_den;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    dir_next    = s_tuser[0];
                    sample_next = s_tdata[SAMPLE_W-1:0];
                    len_next    = len_eff;
                    state_next  = ST_DROP_CHK;
                end
            end
            ST_DROP_CHK:
            begin
                // The read of the oldest entry is issued here in any case.
                if (fill_reg[dir_reg] >= len_reg)
                begin
                    state_next = ST_DROP_SUB;
                end
                else
                begin
                    state_next = ST_STORE;
                end
            end
            ST_DROP_SUB:
            begin
                total_next[dir_reg]  = total_reg[dir_reg] - TOTAL_W'(rd_data_reg);
                oldest_next[dir_reg] = oldest_inc[IDX_W-1:0];
                fill_next[dir_reg]   = fill_reg[dir_reg] - FILL_W'(1);
                state_next           = ST_DROP_CHK;
            end
            ST_STORE:
            begin
                mem_we              = 1'b1;
                fill_next[dir_reg]  = fill_reg[dir_reg] + FILL_W'(1);
                total_next[dir_reg] = total_reg[dir_reg] + TOTAL_W'(sample_reg);
                state_next          = ST_AVG_START;
            end
            ST_AVG_START:
            begin
                div_req.start    = 1'b1;
                div_req.avg_mode = 1'b1;
                div_num          = DIV_W'(total_reg[dir_reg]);
                div_den          = DEN_W'(fill_reg[dir_reg]);
                state_next       = ST_AVG_WAIT;
            end
            ST_AVG_WAIT:
            begin
                if (div_done)
                begin
                    avg_next[dir_reg] = div_quot[SAMPLE_W-1:0];
                    pm_sel_next       = PM_IN;
                    state_next        = ST_PM_MUL;
                end
            end
            ST_PM_MUL:
            begin
                mul_next   = PMNUM_W'(pm_operand) * PMNUM_W'(PERMILLE_SCALE);
                state_next = ST_PM_START;
            end
            ST_PM_START:
            begin
                div_req.start = 1'b1;
                state_next    = ST_PM_WAIT;
            end
            ST_PM_WAIT:
            begin
                if (div_done)
                begin
                    case (pm_sel_reg)
                        PM_IN:
                        begin
                            in_pm_next  = div_quot[PM_W-1:0];
                            pm_sel_next = PM_OUT;
                            state_next  = ST_PM_MUL;
                        end
                        PM_OUT:
                        begin
                            out_pm_next = div_quot[PM_W-1:0];
                            pm_sel_next = PM_TOTAL;
                            state_next  = ST_PM_MUL;
                        end
                        default:
                        begin
                            tot_pm_next = div_quot[PM_W-1:0];
                            state_next  = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_FINISH:
            begin
                // Wait for the output register to free up.
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {tot_pm_reg, out_pm_reg, in_pm_reg,
                                     AVG_W'(avg_reg[DIR_OUT]), AVG_W'(avg_reg[DIR_IN])};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pm_sel_reg   <= PM_IN;
            m_tvalid_reg <= 1'b0;
            for (int d = 0; d < 2; d++)
            begin
                fill_reg[d]   <= '0;
                oldest_reg[d] <= '0;
                total_reg[d]  <= '0;
                avg_reg[d]    <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            pm_sel_reg   <= pm_sel_next;
            m_tvalid_reg <= m_tvalid_next;
            fill_reg     <= fill_next;
            oldest_reg   <= oldest_next;
            total_reg    <= total_next;
            avg_reg      <= avg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg     <= dir_next;
        sample_reg  <= sample_next;
        len_reg     <= len_next;
        mul_reg     <= mul_next;
        in_pm_reg   <= in_pm_next;
        out_pm_reg  <= out_pm_next;
        tot_pm_reg  <= tot_pm_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Configuration registers; the user must write them only while the block is idle, as the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg    <= WLEN_RESET;
            in_cap_reg  <= '0;
            out_cap_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_LENGTH: wlen_reg    <= cfg_data[WLEN_W-1:0];
                REG_IN_CAPACITY:   in_cap_reg  <= cfg_data[CAP_W-1:0];
                REG_OUT_CAPACITY:  out_cap_reg <= cfg_data[CAP_W-1:0];
                default:           wlen_reg    <= wlen_reg;
            endcase
        end
    end

    // Sample memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            win_mem[mem_waddr] <= sample_reg;
        end
        rd_data_reg <= win_mem[mem_raddr];
    end

    wrpa_divider #(
        .DIV_W  (DIV_W),
        .DEN_W  (DEN_W),
        .QW     (QW),
        .AVG_QB (SAMPLE_W)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hw/rtl/wrpa_divider.sv]
// Shared bit-serial restoring divider for averages and per-mille loads.
`timescale 1ns / 1ps

module wrpa_divider #(
    parameter int DIV_W  = 43,
    parameter int DEN_W  = 33,
    parameter int QW     = 32,
    parameter int AVG_QB = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  wrpa_pkg::div_req_t req,
    input  logic [DIV_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output logic               done,
    output logic [QW-1:0]      quot
);
    import wrpa_pkg::*;

    localparam int CMP_W = DIV_W + DEN_W + PM_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DIV_W-1:0] low_reg, low_next;
    logic [QW-1:0]    q_reg, q_next;
    logic [CMP_W-1:0] num_wide;
    logic [CMP_W-1:0] sat_bound;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    // The caller guarantees num >> qbits < den in average mode; in per-mille
    // mode the saturation test establishes it before iterating.
    always_comb
    begin
        num_wide  = CMP_W'(num);
        sat_bound = CMP_W'(den) << PM_W;
        trial     = {rem_reg, low_reg[DIV_W-1]};
        diff      = trial - {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        q_next    = q_reg;

        if (req.start)
        begin
            den_next = den;
            q_next   = '0;
            if (req.avg_mode)
            begin
                rem_next  = DEN_W'(num_wide >> AVG_QB);
                low_next  = num << (DIV_W - AVG_QB);
                cnt_next  = CNT_W'(AVG_QB);
                busy_next = 1'b1;
            end
            else if (den == '0)
            begin
                done_next = 1'b1;
            end
            else if (num_wide >= sat_bound)
            begin
                q_next    = QW'({PM_W{1'b1}});
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = DEN_W'(num_wide >> PM_W);
                low_next  = num << (DIV_W - PM_W);
                cnt_next  = CNT_W'(PM_W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DEN_W-1:0];
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            low_next = low_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        low_reg <= low_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

[hw/rtl/wrpa_checker.sv]
// Port-level checks of the windowed rate averager and their binding.
`timescale 1ns / 1ps

module wrpa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [wrpa_pkg::M_TDATA_W-1:0] m_tdata
);

    // The block works on one request at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while the previous one is in progress");

    // A result needs division after its request, so its valid cannot rise at once.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after its request");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result withdrawn before it was taken");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind windowed_rate_average_permille_unit wrpa_checker u_wrpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
